>>> hdl/scss_pkg.sv
// Package for the sum cover subset search block.
// Holds the word types, configuration defaults and register indexes used by all modules.
// No dependencies.
package scss_pkg;

	localparam int unsigned SCSS_MAX_SIZE = 32;
	localparam int unsigned SCSS_MASK_W = 60;
	localparam int unsigned SCSS_CNT_W = 6;
	localparam int unsigned SCSS_ASPECT_W = 17;
	localparam int unsigned SCSS_PROD_W = 11;
	localparam int unsigned SCSS_MID_DEPTH = 4;
	localparam int unsigned SCSS_OUT_DEPTH = 2;

	localparam logic [SCSS_CNT_W-1:0] SCSS_SIZE_X_RST = 6'd10;
	localparam logic [SCSS_CNT_W-1:0] SCSS_SIZE_Y_RST = 6'd10;
	localparam logic [SCSS_ASPECT_W-1:0] SCSS_MIN_ASPECT_RST = 17'd45875;

	typedef enum logic [1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_MIN_ASPECT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SCSS_MASK_W-1:0] mask;
		logic start_new;
	} in_word_t;

	typedef struct packed {
		logic covers_all;
		logic aspect_ok;
		logic improved;
		logic [SCSS_CNT_W-1:0] kept_cols;
		logic [SCSS_CNT_W-1:0] kept_rows;
		logic best_valid;
		logic [SCSS_MASK_W-1:0] best_mask_out;
		logic [SCSS_CNT_W-1:0] best_cols_out;
		logic [SCSS_CNT_W-1:0] best_rows_out;
	} out_word_t;

	typedef struct packed {
		logic covers_all;
		logic aspect_ok;
		logic [SCSS_CNT_W-1:0] kept_cols;
		logic [SCSS_CNT_W-1:0] kept_rows;
		logic [SCSS_PROD_W-1:0] prod;
		logic [SCSS_MASK_W-1:0] mask;
		logic start_new;
	} mid_word_t;

	typedef struct packed {
		logic [SCSS_CNT_W-1:0] size_x;
		logic [SCSS_CNT_W-1:0] size_y;
		logic [SCSS_ASPECT_W-1:0] min_aspect;
	} cfg_t;

endpackage

>>> hdl/scss_fifo.sv
// Small flip-flop FIFO queue; per cycle one word in unless full, one out unless empty.
// Depends on scss_pkg for the default depth; DEPTH must be a power of two.
module scss_fifo import scss_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = SCSS_MID_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/scss_front.sv
// Front pipeline: decodes a removal mask into kept value sets, checks sum coverage,
// counts kept values and runs the ratio test. Depends on scss_pkg.
module scss_front import scss_pkg::*; #(
	parameter int unsigned MAX_SIZE = SCSS_MAX_SIZE
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_word_t item,
	output logic full,
	input  cfg_t cfg,
	input  logic mid_full,
	output logic mid_push,
	output mid_word_t mid_word
);

	localparam int unsigned N = MAX_SIZE;
	localparam int unsigned SW = 2 * N - 1;
	localparam int unsigned NG = (N + 7) / 8;

	function automatic logic [SCSS_CNT_W-1:0] clamp_size(input logic [SCSS_CNT_W-1:0] s);
		logic [SCSS_CNT_W-1:0] r;
		r = s;
		if (s < 6'd3) begin
			r = 6'd3;
		end else if (s > SCSS_CNT_W'(N)) begin
			r = SCSS_CNT_W'(N);
		end
		return r;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1 signals
	logic [SCSS_CNT_W-1:0] sx_c, sy_c;
	logic [N-1:0] rrev, crev, rdrop, cdrop, rows_d, cols_d;
	logic [SCSS_MASK_W-1:0] mask_hi;
	logic [N-1:0] rows_s1, cols_s1;
	logic [SCSS_CNT_W-1:0] sx_s1, sy_s1;
	logic [SCSS_MASK_W-1:0] mask_s1, mask_s2, mask_s3, mask_s4;
	logic start_s1, start_s2, start_s3, start_s4;

	// Stage 2 signals
	logic [SW-1:0] sums;
	logic cover_d;
	logic [3:0] grp_r_d [NG];
	logic [3:0] grp_c_d [NG];
	logic [3:0] grp_r_s2 [NG];
	logic [3:0] grp_c_s2 [NG];
	logic cover_s2, cover_s3, cover_s4;

	// Stage 3 and 4 signals
	logic [SCSS_CNT_W-1:0] kr_d, kc_d, kr_s3, kc_s3, kr_s4, kc_s4;
	logic [SCSS_CNT_W-1:0] lo, hi;
	logic [SCSS_ASPECT_W+SCSS_CNT_W-1:0] lhs, rhs;
	logic aspect_s4;
	logic [SCSS_PROD_W-1:0] prod_s4;

	// The whole pipe moves together; it stalls only when its last word cannot enter the queue.
	assign en = !v_s4 || !mid_full;
	assign full = !en;
	assign mid_push = v_s4 && !mid_full;

	// Mask bit sy-2-v drops row v; reversing the low bits turns that into a plain shift.
	always_comb begin
		sx_c = clamp_size(cfg.size_x);
		sy_c = clamp_size(cfg.size_y);
		mask_hi = item.mask >> (sy_c - 6'd2);
		for (int j = 0; j < N; j++) begin
			rrev[j] = item.mask[N-1-j];
			crev[j] = mask_hi[N-1-j];
		end
		rdrop = rrev >> (SCSS_CNT_W'(N + 1) - sy_c);
		cdrop = crev >> (SCSS_CNT_W'(N + 1) - sx_c);
		for (int v = 0; v < N; v++) begin
			rows_d[v] = (SCSS_CNT_W'(v) < sy_c) &&
				!((v >= 1) && (SCSS_CNT_W'(v + 2) <= sy_c) && rdrop[v]);
			cols_d[v] = (SCSS_CNT_W'(v) < sx_c) &&
				!((v >= 1) && (SCSS_CNT_W'(v + 2) <= sx_c) && cdrop[v]);
		end
	end

	always_comb begin
		for (int s = 0; s < SW; s++) begin
			sums[s] = 1'b0;
			for (int v = 0; v < N; v++) begin
				if ((s >= v) && (s - v < N)) begin
					sums[s] = sums[s] | (cols_s1[v] & rows_s1[s-v]);
				end
			end
		end
		cover_d = 1'b1;
		for (int s = 0; s < SW; s++) begin
			if (7'(s + 1) < ({1'b0, sx_s1} + {1'b0, sy_s1})) begin
				cover_d = cover_d & sums[s];
			end
		end
		for (int g = 0; g < NG; g++) begin
			grp_r_d[g] = '0;
			grp_c_d[g] = '0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < N) begin
					grp_r_d[g] = grp_r_d[g] + 4'(rows_s1[g*8+j]);
					grp_c_d[g] = grp_c_d[g] + 4'(cols_s1[g*8+j]);
				end
			end
		end
	end

	always_comb begin
		kr_d = '0;
		kc_d = '0;
		for (int g = 0; g < NG; g++) begin
			kr_d = kr_d + SCSS_CNT_W'(grp_r_s2[g]);
			kc_d = kc_d + SCSS_CNT_W'(grp_c_s2[g]);
		end
	end

	// The ratio test is done exactly: lo * 2^16 >= min_aspect * hi.
	always_comb begin
		lo = (kc_s3 < kr_s3) ? kc_s3 : kr_s3;
		hi = (kc_s3 < kr_s3) ? kr_s3 : kc_s3;
		lhs = {1'b0, lo, 16'd0};
		rhs = {{SCSS_CNT_W{1'b0}}, cfg.min_aspect} * {{SCSS_ASPECT_W{1'b0}}, hi};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rows_s1 <= rows_d;
			cols_s1 <= cols_d;
			sx_s1 <= sx_c;
			sy_s1 <= sy_c;
			mask_s1 <= item.mask;
			start_s1 <= item.start_new;

			cover_s2 <= cover_d;
			grp_r_s2 <= grp_r_d;
			grp_c_s2 <= grp_c_d;
			mask_s2 <= mask_s1;
			start_s2 <= start_s1;

			cover_s3 <= cover_s2;
			kr_s3 <= kr_d;
			kc_s3 <= kc_d;
			mask_s3 <= mask_s2;
			start_s3 <= start_s2;

			cover_s4 <= cover_s3;
			aspect_s4 <= (lhs >= rhs);
			prod_s4 <= {{(SCSS_PROD_W-SCSS_CNT_W){1'b0}}, kc_s3} *
				{{(SCSS_PROD_W-SCSS_CNT_W){1'b0}}, kr_s3};
			kr_s4 <= kr_s3;
			kc_s4 <= kc_s3;
			mask_s4 <= mask_s3;
			start_s4 <= start_s3;
		end
	end

	always_comb begin
		mid_word.covers_all = cover_s4;
		mid_word.aspect_ok = aspect_s4;
		mid_word.kept_cols = kc_s4;
		mid_word.kept_rows = kr_s4;
		mid_word.prod = prod_s4;
		mid_word.mask = mask_s4;
		mid_word.start_new = start_s4;
	end

endmodule

>>> hdl/scss_back.sv
// Back end: keeps the best passing mask and builds the result word for each evaluated mask.
// Depends on scss_pkg.
module scss_back import scss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  mid_word_t mid_word,
	input  logic mid_empty,
	output logic mid_pop,
	input  logic out_full,
	output logic out_push,
	output out_word_t out_word
);

	logic have_best_q;
	logic [SCSS_MASK_W-1:0] best_mask_q;
	logic [SCSS_CNT_W-1:0] best_cols_q;
	logic [SCSS_CNT_W-1:0] best_rows_q;
	logic [SCSS_PROD_W-1:0] best_prod_q;

	logic have_eff;
	logic [SCSS_MASK_W-1:0] mask_eff;
	logic [SCSS_CNT_W-1:0] cols_eff, rows_eff;
	logic [SCSS_PROD_W-1:0] prod_eff;
	logic take;
	logic have_nxt;
	logic [SCSS_MASK_W-1:0] mask_nxt;
	logic [SCSS_CNT_W-1:0] cols_nxt, rows_nxt;
	logic [SCSS_PROD_W-1:0] prod_nxt;

	assign mid_pop = !mid_empty && !out_full;
	assign out_push = mid_pop;

	// A clear request wipes the best before this word is compared against it.
	always_comb begin
		have_eff = have_best_q && !mid_word.start_new;
		mask_eff = mid_word.start_new ? '0 : best_mask_q;
		cols_eff = mid_word.start_new ? '0 : best_cols_q;
		rows_eff = mid_word.start_new ? '0 : best_rows_q;
		prod_eff = mid_word.start_new ? '0 : best_prod_q;
		take = mid_word.covers_all && mid_word.aspect_ok &&
			(!have_eff || (mid_word.prod < prod_eff));
		have_nxt = take ? 1'b1 : have_eff;
		mask_nxt = take ? mid_word.mask : mask_eff;
		cols_nxt = take ? mid_word.kept_cols : cols_eff;
		rows_nxt = take ? mid_word.kept_rows : rows_eff;
		prod_nxt = take ? mid_word.prod : prod_eff;

		out_word.covers_all = mid_word.covers_all;
		out_word.aspect_ok = mid_word.aspect_ok;
		out_word.improved = take;
		out_word.kept_cols = mid_word.kept_cols;
		out_word.kept_rows = mid_word.kept_rows;
		out_word.best_valid = have_nxt;
		out_word.best_mask_out = mask_nxt;
		out_word.best_cols_out = cols_nxt;
		out_word.best_rows_out = rows_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_mask_q <= '0;
			best_cols_q <= '0;
			best_rows_q <= '0;
			best_prod_q <= '0;
		end else if (mid_pop) begin
			have_best_q <= have_nxt;
			best_mask_q <= mask_nxt;
			best_cols_q <= cols_nxt;
			best_rows_q <= rows_nxt;
			best_prod_q <= prod_nxt;
		end
	end

endmodule

>>> hdl/sum_cover_subset_search.sv
// Top level of the sum cover subset search block: configuration registers and the queues
// that join the front pipeline and the best tracker. Depends on scss_pkg and all scss modules.
//
// One mask word is accepted per clock cycle while full is low, and one result word leaves per
// cycle while empty is low. A mask passes through the front pipeline (set decode, coverage and
// partial counts, count totals, ratio test), then a four-word queue into the best tracker, which
// settles one word a cycle unless the result queue is full, and lands in a two-word result queue.
// full rises only when the front pipeline is stalled by a full middle queue. Registers: size_x
// at byte 0, size_y at byte 4, min_aspect at byte 8; sizes outside 3 to MAX_SIZE are clamped,
// and mask bits beyond the used values are ignored.
module sum_cover_subset_search import scss_pkg::*; #(
	parameter int unsigned MAX_SIZE = SCSS_MAX_SIZE
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_word_t item,
	output logic empty,
	input  logic pop,
	output out_word_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic mid_full, mid_push, mid_empty, mid_pop;
	mid_word_t mid_in, mid_out;
	logic out_full, out_push;
	out_word_t out_in;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x <= SCSS_SIZE_X_RST;
			cfg_q.size_y <= SCSS_SIZE_Y_RST;
			cfg_q.min_aspect <= SCSS_MIN_ASPECT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SIZE_X: cfg_q.size_x <= pwdata[SCSS_CNT_W-1:0];
				REG_SIZE_Y: cfg_q.size_y <= pwdata[SCSS_CNT_W-1:0];
				REG_MIN_ASPECT: cfg_q.min_aspect <= pwdata[SCSS_ASPECT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SIZE_X: prdata = {26'd0, cfg_q.size_x};
			REG_SIZE_Y: prdata = {26'd0, cfg_q.size_y};
			REG_MIN_ASPECT: prdata = {15'd0, cfg_q.min_aspect};
			default: prdata = '0;
		endcase
	end

	scss_front #(
		.MAX_SIZE(MAX_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.cfg(cfg_q),
		.mid_full(mid_full),
		.mid_push(mid_push),
		.mid_word(mid_in)
	);

	scss_fifo #(
		.WIDTH($bits(mid_word_t)),
		.DEPTH(SCSS_MID_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.wdata(mid_in),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_out),
		.empty(mid_empty)
	);

	scss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mid_word(mid_out),
		.mid_empty(mid_empty),
		.mid_pop(mid_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_word(out_in)
	);

	scss_fifo #(
		.WIDTH($bits(out_word_t)),
		.DEPTH(SCSS_OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(out_in),
		.full(out_full),
		.pop(pop),
		.rdata(result),
		.empty(empty)
	);

endmodule
